// ----- design/gslm_pkg.sv -----
// ----------------------------------------------------------------------------
// gslm_pkg: shared types and constants
// Register indexes, queue depth, the control word that travels from the
// classifier to the decision engine, and the engine's state codes.
// ----------------------------------------------------------------------------
package gslm_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FL_USE,
    ST_FL_LAST
  } gslm_state_t;

  typedef struct packed {
    logic [15:0] row;
    logic        end_row;
    logic        end_grid;
  } gslm_ctl_t;

endpackage

// ----- design/gslm_front.sv -----
// ----------------------------------------------------------------------------
// gslm_front: configuration registers and raster position tracking
// Clamps the position counters to the current grid size and tags each
// accepted word with its row, column and end-of-row / end-of-grid flags.
// ----------------------------------------------------------------------------
module gslm_front import gslm_pkg::*; #(
  parameter int MAX_COLS = 32,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_wdata,
  input  logic          in_valid,
  input  logic          in_stall,
  output logic [CW-1:0] q_col,
  output gslm_ctl_t     q_ctl
);

  logic [15:0]   rows_r;
  logic [5:0]    cols_r;
  logic [15:0]   row_idx_r;
  logic [CW-1:0] col_idx_r;

  logic [15:0]   row_last;
  logic [CW-1:0] col_last;
  logic [15:0]   row_cur;
  logic [CW-1:0] col_cur;
  logic          end_row;
  logic          end_grid;
  logic          accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 16'd1;
      cols_r <= 6'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_ROWS: rows_r <= cfg_wdata;
        REG_GRID_COLS: cols_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // zero counts act as one, column count saturates at the buffer depth
  always_comb begin
    row_last = (rows_r == 16'd0) ? 16'd0 : rows_r - 16'd1;
    if (cols_r == 6'd0) begin
      col_last = '0;
    end else if ({1'b0, cols_r} > 7'(MAX_COLS)) begin
      col_last = CW'(MAX_COLS - 1);
    end else begin
      col_last = CW'(cols_r - 6'd1);
    end
    row_cur  = (row_idx_r > row_last) ? row_last : row_idx_r;
    col_cur  = (col_idx_r > col_last) ? col_last : col_idx_r;
    end_row  = (col_cur == col_last);
    end_grid = end_row && (row_cur == row_last);
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_idx_r <= '0;
      col_idx_r <= '0;
    end else if (accept) begin
      if (end_row) begin
        col_idx_r <= '0;
        row_idx_r <= end_grid ? 16'd0 : row_cur + 16'd1;
      end else begin
        col_idx_r <= col_cur + CW'(1);
      end
    end
  end

  assign q_col          = col_cur;
  assign q_ctl.row      = row_cur;
  assign q_ctl.end_row  = end_row;
  assign q_ctl.end_grid = end_grid;

endmodule

// ----- design/gslm_queue.sv -----
// ----------------------------------------------------------------------------
// gslm_queue: small register FIFO between classifier and decision engine
// Lets the front keep accepting words while the back drains a flush.
// ----------------------------------------------------------------------------
module gslm_queue import gslm_pkg::*; #(
  parameter int WIDTH = 39
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_stall,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_stall,
  output logic [WIDTH-1:0] rd_data
);

  localparam int QA = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [QA-1:0]    wr_ptr_r;
  logic [QA-1:0]    rd_ptr_r;
  logic [QA:0]      count_r;
  logic             push;
  logic             pop;

  assign wr_stall = (count_r == (QA+1)'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;
  assign rd_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QA'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QA'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QA'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QA'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + (QA+1)'(1);
        2'b01:   count_r <= count_r - (QA+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- design/gslm_back.sv -----
// ----------------------------------------------------------------------------
// gslm_back: line buffers, 3x3 window and peak decisions
// Three rotating row banks hold the two previous rows and the current one.
// Each word past the first row and column decides the cell up and to the left;
// a row end also decides the last cell of the row above, and a grid end sweeps
// the final row.
module gslm_back import gslm_pkg::*; #(
  parameter int MAX_COLS    = 32,
  parameter int VALUE_WIDTH = 16,
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_stall,
  input  logic signed [VALUE_WIDTH-1:0] q_value,
  input  logic [CW-1:0]                 q_col,
  input  gslm_ctl_t                     q_ctl,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   out_cell_row,
  output logic [4:0]                    out_cell_col,
  output logic                          out_is_peak,
  output logic                          out_last_of_run
);

  typedef logic signed [VALUE_WIDTH-1:0] val_t;

  function automatic logic [1:0] b_dec(input logic [1:0] b);
    return (b == 2'd0) ? 2'd2 : b - 2'd1;
  endfunction

  function automatic logic [1:0] b_inc(input logic [1:0] b);
    return (b == 2'd2) ? 2'd0 : b + 2'd1;
  endfunction

  function automatic val_t pick(input logic [1:0] sel, input val_t a0, input val_t a1,
                                input val_t a2);
    val_t v;
    case (sel)
      2'd0:    v = a0;
      2'd1:    v = a1;
      default: v = a2;
    endcase
    return v;
  endfunction

  function automatic logic gt(input val_t a, input val_t b);
    return a > b;
  endfunction

  gslm_state_t   state_r;
  gslm_state_t   state_nxt;
  logic [1:0]    ptr_r;

  logic          s2_valid_r;
  val_t          s2_val_r;
  logic [15:0]   s2_row_r;
  logic [CW-1:0] s2_col_r;
  logic          s2_end_row_r;
  logic          s2_end_grid_r;
  logic [1:0]    s2_ptr_r;
  logic          a_done_r;

  val_t          bq_r [3];
  val_t          w_ab_r [2];
  val_t          w_md_r [2];
  val_t          w_bl_r [2];
  val_t          f_ab_r [2];
  val_t          f_md_r [2];
  logic [CW-1:0] fk_r;

  logic          out_valid_r;
  logic [15:0]   out_row_r;
  logic [4:0]    out_col_r;
  logic          out_peak_r;
  logic          out_last_r;

  logic          rd_en;
  logic [CW-1:0] rd_addr;
  logic          pop;
  logic          pop_ok;
  logic          retire;
  logic          a_fire;
  logic          fl_issue;
  logic          fl_adv;
  logic          out_free;
  logic          em_valid;
  logic          em_fire;
  logic [15:0]   em_row;
  logic [CW-1:0] em_col;
  logic          em_peak;
  logic          em_last;
  logic          pend_a;
  logic          pend_b;

  val_t          tb;
  val_t          bf;
  val_t          fm;
  logic          has_r1;
  logic          has_up;
  logic          c_ge1;
  logic          c_ge2;
  logic          k_ge1;
  logic          k_ge2;
  logic          peak_a;
  logic          peak_b;
  logic          peak_f;
  logic          peak_l;

  // row banks: write the incoming word into the current row, read a column of
  // every bank into registered outputs
  for (genvar b = 0; b < 3; b++) begin : g_bank
    val_t mem [MAX_COLS];
    always_ff @(posedge clk) begin
      if (pop && ptr_r == 2'(b)) begin
        mem[q_col] <= q_value;
      end
      if (rd_en) begin
        bq_r[b] <= mem[rd_addr];
      end
    end
  end

  assign bf = pick(b_dec(s2_ptr_r), bq_r[0], bq_r[1], bq_r[2]);
  assign tb = pick(b_dec(b_dec(s2_ptr_r)), bq_r[0], bq_r[1], bq_r[2]);
  assign fm = pick(s2_ptr_r, bq_r[0], bq_r[1], bq_r[2]);

  assign has_r1 = (s2_row_r != 16'd0);
  assign has_up = (s2_row_r >= 16'd2);
  assign c_ge1  = (s2_col_r != '0);
  assign c_ge2  = (s2_col_r > CW'(1));
  assign k_ge1  = (fk_r != '0);
  assign k_ge2  = (fk_r > CW'(1));

  // cell one row up, one column left; the new column is on its right
  assign peak_a = gt(w_md_r[1], w_bl_r[1]) && (!has_up || gt(w_md_r[1], w_ab_r[1]))
               && (!c_ge2 || (gt(w_md_r[1], w_md_r[0]) && gt(w_md_r[1], w_bl_r[0])
                              && (!has_up || gt(w_md_r[1], w_ab_r[0]))))
               && gt(w_md_r[1], bf) && gt(w_md_r[1], s2_val_r)
               && (!has_up || gt(w_md_r[1], tb));

  // last cell of the row above: no right neighbor
  assign peak_b = gt(bf, s2_val_r) && (!has_up || gt(bf, tb))
               && (!c_ge1 || (gt(bf, w_md_r[1]) && gt(bf, w_bl_r[1])
                              && (!has_up || gt(bf, w_ab_r[1]))));

  // final row sweep: no row below
  assign peak_f = gt(f_md_r[1], fm) && (!has_r1 || gt(f_md_r[1], bf))
               && (!has_r1 || gt(f_md_r[1], f_ab_r[1]))
               && (!k_ge2 || (gt(f_md_r[1], f_md_r[0])
                              && (!has_r1 || gt(f_md_r[1], f_ab_r[0]))));

  assign peak_l = (!has_r1 || gt(f_md_r[1], f_ab_r[1]))
               && (!c_ge1 || (gt(f_md_r[1], f_md_r[0])
                              && (!has_r1 || gt(f_md_r[1], f_ab_r[0]))));

  assign out_free = !out_valid_r || !out_stall;
  assign em_fire  = em_valid && out_free;
  assign pop      = q_valid && pop_ok;
  assign q_stall  = !pop_ok;
  assign rd_en    = pop || fl_issue;
  assign rd_addr  = pop ? q_col : ((state_r == ST_RUN) ? '0 : fk_r + CW'(1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (retire && s2_end_grid_r) begin
          state_nxt = ST_FL_USE;
        end
      end
      ST_FL_USE: begin
        if (fl_adv && fk_r == s2_col_r) begin
          state_nxt = ST_FL_LAST;
        end
      end
      ST_FL_LAST: begin
        if (out_free) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_comb begin
    em_valid = 1'b0;
    em_row   = s2_row_r;
    em_col   = s2_col_r;
    em_peak  = 1'b0;
    em_last  = 1'b0;
    pend_a   = 1'b0;
    pend_b   = 1'b0;
    retire   = 1'b0;
    a_fire   = 1'b0;
    pop_ok   = 1'b0;
    fl_issue = 1'b0;
    fl_adv   = 1'b0;
    case (state_r)
      ST_RUN: begin
        pend_a = s2_valid_r && has_r1 && c_ge1 && !a_done_r;
        pend_b = s2_valid_r && has_r1 && s2_end_row_r;
        if (pend_a) begin
          em_valid = 1'b1;
          em_row   = s2_row_r - 16'd1;
          em_col   = s2_col_r - CW'(1);
          em_peak  = peak_a;
          em_last  = !pend_b && !s2_end_grid_r;
        end else if (pend_b) begin
          em_valid = 1'b1;
          em_row   = s2_row_r - 16'd1;
          em_peak  = peak_b;
          em_last  = !s2_end_grid_r;
        end
        retire   = s2_valid_r && (!em_valid || (out_free && !(pend_a && pend_b)));
        a_fire   = out_free && pend_a && pend_b;
        pop_ok   = !s2_valid_r || (retire && !s2_end_grid_r);
        fl_issue = retire && s2_end_grid_r;
      end
      ST_FL_USE: begin
        em_valid = k_ge1;
        em_col   = fk_r - CW'(1);
        em_peak  = peak_f;
        fl_adv   = !k_ge1 || out_free;
        fl_issue = fl_adv && (fk_r != s2_col_r);
      end
      ST_FL_LAST: begin
        em_valid = 1'b1;
        em_peak  = peak_l;
        em_last  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_RUN;
      ptr_r      <= 2'd0;
      s2_valid_r <= 1'b0;
      a_done_r   <= 1'b0;
      fk_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (pop) begin
        s2_valid_r <= 1'b1;
        a_done_r   <= 1'b0;
        if (q_ctl.end_row) begin
          ptr_r <= b_inc(ptr_r);
        end
      end else if (state_r == ST_RUN && retire && !s2_end_grid_r) begin
        s2_valid_r <= 1'b0;
      end else if (state_r == ST_FL_LAST && out_free) begin
        s2_valid_r <= 1'b0;
      end
      if (a_fire) begin
        a_done_r <= 1'b1;
      end
      if (fl_issue) begin
        fk_r <= (state_r == ST_RUN) ? '0 : fk_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_val_r      <= q_value;
      s2_row_r      <= q_ctl.row;
      s2_col_r      <= q_col;
      s2_end_row_r  <= q_ctl.end_row;
      s2_end_grid_r <= q_ctl.end_grid;
      s2_ptr_r      <= ptr_r;
    end
    // advance the window by one column as each word retires
    if (state_r == ST_RUN && retire) begin
      w_ab_r[0] <= w_ab_r[1];
      w_md_r[0] <= w_md_r[1];
      w_bl_r[0] <= w_bl_r[1];
      w_ab_r[1] <= tb;
      w_md_r[1] <= bf;
      w_bl_r[1] <= s2_val_r;
    end
    if (state_r == ST_FL_USE && fl_adv) begin
      f_ab_r[0] <= f_ab_r[1];
      f_md_r[0] <= f_md_r[1];
      f_ab_r[1] <= bf;
      f_md_r[1] <= fm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (em_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (em_fire) begin
      out_row_r  <= em_row;
      out_col_r  <= 5'(32'(em_col));
      out_peak_r <= em_peak;
      out_last_r <= em_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_row    = out_row_r;
  assign out_cell_col    = out_col_r;
  assign out_is_peak     = out_peak_r;
  assign out_last_of_run = out_last_r;

`ifndef SYNTHESIS
  a_sweep_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> s2_valid_r)
    else $error("final row sweep running without its word");

  a_sweep_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FL_USE) |-> (fk_r <= s2_col_r))
    else $error("sweep column past the end of the row");

  a_grid_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_end_grid_r) |-> s2_end_row_r)
    else $error("grid end tagged on a word that does not end a row");

  a_first_done_only_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && a_done_r) |-> s2_end_row_r)
    else $error("split decision on a word that does not end a row");

  a_last_waits_for_sink: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FL_LAST && out_valid_r && out_stall) |=> (state_r == ST_FL_LAST))
    else $error("sweep finished while the sink stalled");
`endif

endmodule

// ----- design/grid_strict_local_max_3x3_top.sv -----
// Stages: a taken word is registered in the decision stage, its result in the
//   output register. Throughput: one word per cycle when the sink takes it;
//   a row end holds the engine for a second decision, and the grid end holds
//   it to sweep the final row through the single read port of each row bank.
// Reset: row and column counters clear, grid size returns to 1 x 1, queue and
//   output empty; the row buffers keep their contents and need no clearing.
// ----------------------------------------------------------------------------
// grid_strict_local_max_3x3_top: 3x3 strict local maximum over a raster grid
// Front tags each word with its grid position, a short queue decouples it
// from the back that keeps the row buffers and decides every cell.
// ----------------------------------------------------------------------------
module grid_strict_local_max_3x3_top import gslm_pkg::*; #(
  parameter int MAX_COLS    = 32,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [15:0]                   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [VALUE_WIDTH-1:0] in_cell_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [15:0]                   out_cell_row,
  output logic [4:0]                    out_cell_col,
  output logic                          out_is_peak,
  output logic                          out_last_of_run
);

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int QW = VALUE_WIDTH + CW + $bits(gslm_ctl_t);

  logic [CW-1:0]                 fr_col;
  gslm_ctl_t                     fr_ctl;
  logic [QW-1:0]                 q_wr_data;
  logic [QW-1:0]                 q_rd_data;
  logic                          q_valid;
  logic                          q_stall;
  logic signed [VALUE_WIDTH-1:0] bk_value;
  logic [CW-1:0]                 bk_col;
  gslm_ctl_t                     bk_ctl;

  gslm_front #(
    .MAX_COLS (MAX_COLS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .q_col     (fr_col),
    .q_ctl     (fr_ctl)
  );

  assign q_wr_data = {in_cell_value, fr_col, fr_ctl};

  gslm_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_stall (in_stall),
    .wr_data  (q_wr_data),
    .rd_valid (q_valid),
    .rd_stall (q_stall),
    .rd_data  (q_rd_data)
  );

  assign {bk_value, bk_col, bk_ctl} = q_rd_data;

  gslm_back #(
    .MAX_COLS    (MAX_COLS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_stall         (q_stall),
    .q_value         (bk_value),
    .q_col           (bk_col),
    .q_ctl           (bk_ctl),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cell_row    (out_cell_row),
    .out_cell_col    (out_cell_col),
    .out_is_peak     (out_is_peak),
    .out_last_of_run (out_last_of_run)
  );

endmodule
